// ===== sv/inverter_packet_framer_macros.svh =====
// ----------------------------------------------------------------------------
// Inverter packet framer: assertion macros
// Shorthand for the clocked, reset-qualified properties of the port checker.
// ----------------------------------------------------------------------------
`ifndef INVERTER_PACKET_FRAMER_MACROS_SVH
`define INVERTER_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted
`define IPF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: port rule violated");

// Next-cycle implication, quiet while reset is asserted
`define IPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: port rule violated");

// Next-cycle implication that also runs through reset
`define IPF_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: reset rule violated");

`endif

// ===== sv/ipf_pkg.sv =====
// ----------------------------------------------------------------------------
// Inverter packet framer package
// Shared constants, the command record with its kind codes, and the queue status record.
// ----------------------------------------------------------------------------
package ipf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDRESS   = 1'b1;

  // Input kind carried on in_tuser
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_PAYLOAD = 1'b1;

  // Fixed frame bytes
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hA5;
  localparam logic [BYTE_W-1:0] LF_BYTE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CR_BYTE   = 8'h0D;
  localparam logic [BYTE_W-1:0] ERR_BYTE  = 8'h00;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_DATA,
    CMD_ORPHAN
  } cmd_kind_t;

  // One classified input transaction, queued for the byte sequencer
  typedef struct packed {
    cmd_kind_t         kind;
    logic              trailer;   // close the frame with checksum and CR/LF
    logic [BYTE_W-1:0] src;
    logic [BYTE_W-1:0] dst;
    logic [BYTE_W-1:0] ctrl;
    logic [BYTE_W-1:0] func;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] data;
    logic [SUM_W-1:0]  cksum;
  } cmd_t;

  // Queue status seen by the producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/inverter_packet_framer.sv =====
// ----------------------------------------------------------------------------
// Inverter packet framer
// Builds request frames for a serial inverter link from a stream of input
// transactions.
// ----------------------------------------------------------------------------
// A start transaction yields the header A5 A5, source, destination, control
// code, function code and length (7 bytes, or 11 with checksum and 0A 0D when
// the length is zero); each payload transaction yields its byte, plus 4 more
// bytes when it is the last of the frame; a payload byte with no open frame
// yields one error byte. The front end takes one input transaction per cycle
// while its command queue (QUEUE_DEPTH entries) has room; the byte sequencer
// behind it emits one byte per cycle unless the output stalls, so a steady
// stream of payload bytes runs at one per cycle. Source and destination
// addresses are sampled when a frame starts.
// ----------------------------------------------------------------------------
module inverter_packet_framer import ipf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // control_code, function_code,
                                           // payload_length, data_byte
  input  logic [0:0]           in_tuser,   // mode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [BYTE_W-1:0]    out_tdata,  // out_byte
  output logic                 out_tlast,  // frame_end
  output logic [0:0]           out_tuser,  // error
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  q_stat_t q_stat;
  cmd_t    push_cmd, head;
  logic    push, pop;

  assign cfg_ready = 1'b1;

  ipf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .mode           (in_tuser[0]),
    .control_code   (in_tdata[7:0]),
    .function_code  (in_tdata[15:8]),
    .payload_length (in_tdata[23:16]),
    .data_byte      (in_tdata[31:24]),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_stat         (q_stat),
    .push           (push),
    .cmd            (push_cmd)
  );

  ipf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  ipf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .frame_end (out_tlast),
    .error     (out_tuser[0])
  );

endmodule

// ===== sv/ipf_front.sv =====
// ----------------------------------------------------------------------------
// Inverter packet framer: front end
// Accepts input transactions, tracks the open frame and its running sum,
// and turns each transaction into one command for the queue.
// ----------------------------------------------------------------------------
module ipf_front import ipf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic [BYTE_W-1:0]    control_code,
  input  logic [BYTE_W-1:0]    function_code,
  input  logic [BYTE_W-1:0]    payload_length,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  q_stat_t              q_stat,
  output logic                 push,
  output cmd_t                 cmd
);

  logic [BYTE_W-1:0] src_r, dst_r;
  logic [SUM_W-1:0]  sum_acc_r, sum_acc_nxt;
  logic [BYTE_W-1:0] bytes_left_r, bytes_left_nxt;
  logic              frame_open_r, frame_open_nxt;
  logic [SUM_W-1:0]  hdr_sum, data_sum;
  logic              accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  // Sums that the start and payload cases add to the frame
  assign hdr_sum = SUM_W'(SYNC_BYTE) + SUM_W'(SYNC_BYTE) + SUM_W'(src_r) + SUM_W'(dst_r)
                 + SUM_W'(control_code) + SUM_W'(function_code) + SUM_W'(payload_length);
  assign data_sum = sum_acc_r + SUM_W'(data_byte);

  // Classify the transaction and work out the frame state it leaves
  always_comb begin
    cmd.src         = src_r;
    cmd.dst         = dst_r;
    cmd.ctrl        = control_code;
    cmd.func        = function_code;
    cmd.len         = payload_length;
    cmd.data        = data_byte;
    cmd.kind        = CMD_ORPHAN;
    cmd.trailer     = 1'b0;
    cmd.cksum       = '0;
    sum_acc_nxt     = sum_acc_r;
    bytes_left_nxt  = bytes_left_r;
    frame_open_nxt  = frame_open_r;
    priority if (mode == MODE_START) begin
      cmd.kind = CMD_START;
      if (payload_length == '0) begin
        cmd.trailer    = 1'b1;
        cmd.cksum      = SUM_W'(0) - hdr_sum;
        sum_acc_nxt    = '0;
        bytes_left_nxt = '0;
        frame_open_nxt = 1'b0;
      end else begin
        sum_acc_nxt    = hdr_sum;
        bytes_left_nxt = payload_length;
        frame_open_nxt = 1'b1;
      end
    end else if (frame_open_r) begin
      cmd.kind = CMD_DATA;
      if (bytes_left_r == BYTE_W'(1)) begin
        cmd.trailer    = 1'b1;
        cmd.cksum      = SUM_W'(0) - data_sum;
        sum_acc_nxt    = '0;
        bytes_left_nxt = '0;
        frame_open_nxt = 1'b0;
      end else begin
        sum_acc_nxt    = data_sum;
        bytes_left_nxt = bytes_left_r - BYTE_W'(1);
      end
    end else begin
      // Stray payload byte: one error byte, frame state untouched
      cmd.kind = CMD_ORPHAN;
    end
  end

  // Hold frame state; advance it on each accepted transaction and load addresses from cfg writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_acc_r    <= '0;
      bytes_left_r <= '0;
      frame_open_r <= 1'b0;
      src_r        <= '0;
      dst_r        <= '0;
    end else begin
      if (accept) begin
        sum_acc_r    <= sum_acc_nxt;
        bytes_left_r <= bytes_left_nxt;
        frame_open_r <= frame_open_nxt;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SOURCE_ADDRESS: src_r <= cfg_data;
          REG_DEST_ADDRESS:   dst_r <= cfg_data;
          default:            ;
        endcase
      end
    end
  end

endmodule

// ===== sv/ipf_queue.sv =====
// ----------------------------------------------------------------------------
// Inverter packet framer: command queue
// Small first-in first-out buffer that decouples the front end from the
// byte sequencer.
// ----------------------------------------------------------------------------
module ipf_queue import ipf_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== sv/ipf_back.sv =====
// ----------------------------------------------------------------------------
// Inverter packet framer: byte sequencer
// Expands each queued command into its wire bytes, one per cycle unless the
// output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module ipf_back import ipf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              head,
  input  q_stat_t           q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              frame_end,
  output logic              error
);

  typedef enum logic [3:0] {
    ST_HDR0, ST_HDR1, ST_HDR2, ST_HDR3, ST_HDR4, ST_HDR5, ST_HDR6,
    ST_CK_HI, ST_CK_LO, ST_LF, ST_CR, ST_DATA, ST_ERR
  } step_t;

  step_t             step_r, cur_step, next_step;
  logic              busy_r;
  logic              out_valid_r, out_last_r, out_err_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              load, fire, last_step;
  logic [BYTE_W-1:0] cur_byte;

  assign load = !out_valid_r || out_ready;
  assign fire = load && !q_stat.empty;
  assign pop  = fire && last_step;

  // Pick the step: first step of a fresh command, else the one in progress
  always_comb begin
    cur_step = step_r;
    if (!busy_r) begin
      unique case (head.kind)
        CMD_START: cur_step = ST_HDR0;
        CMD_DATA:  cur_step = ST_DATA;
        default:   cur_step = ST_ERR;
      endcase
    end
  end

  // Byte for the current step and where the sequence goes next
  always_comb begin
    cur_byte  = ERR_BYTE;
    next_step = ST_ERR;
    last_step = 1'b0;
    unique case (cur_step)
      ST_HDR0:  begin cur_byte = SYNC_BYTE;          next_step = ST_HDR1;  end
      ST_HDR1:  begin cur_byte = SYNC_BYTE;          next_step = ST_HDR2;  end
      ST_HDR2:  begin cur_byte = head.src;           next_step = ST_HDR3;  end
      ST_HDR3:  begin cur_byte = head.dst;           next_step = ST_HDR4;  end
      ST_HDR4:  begin cur_byte = head.ctrl;          next_step = ST_HDR5;  end
      ST_HDR5:  begin cur_byte = head.func;          next_step = ST_HDR6;  end
      ST_HDR6:  begin
        cur_byte  = head.len;
        next_step = ST_CK_HI;
        last_step = !head.trailer;
      end
      ST_DATA:  begin
        cur_byte  = head.data;
        next_step = ST_CK_HI;
        last_step = !head.trailer;
      end
      ST_CK_HI: begin cur_byte = head.cksum[SUM_W-1 -: BYTE_W]; next_step = ST_CK_LO; end
      ST_CK_LO: begin cur_byte = head.cksum[BYTE_W-1:0];        next_step = ST_LF;    end
      ST_LF:    begin cur_byte = LF_BYTE;            next_step = ST_CR;    end
      ST_CR:    begin cur_byte = CR_BYTE;            last_step = 1'b1;     end
      ST_ERR:   begin cur_byte = ERR_BYTE;           last_step = 1'b1;     end
      default:  begin cur_byte = ERR_BYTE;           last_step = 1'b1;     end
    endcase
  end

  // Hold sequencer state and the output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= ST_HDR0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= fire;
      if (fire) begin
        out_byte_r <= cur_byte;
        out_last_r <= (cur_step == ST_CR);
        out_err_r  <= (cur_step == ST_ERR);
        busy_r     <= !last_step;
        step_r     <= next_step;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign frame_end = out_last_r;
  assign error     = out_err_r;

endmodule

// ===== sv/ipf_checker.sv =====
// ----------------------------------------------------------------------------
// Inverter packet framer: port checker
// Watches the top-level ports for framing and output-stage rules.
// ----------------------------------------------------------------------------
`include "inverter_packet_framer_macros.svh"

module ipf_checker import ipf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [BYTE_W-1:0] out_tdata,
  input logic              out_tlast,
  input logic [0:0]        out_tuser
);

  // Frame end falls only on the carriage-return trailer byte
  `IPF_ASSERT_SAME(a_last_is_cr, out_tvalid && out_tlast, out_tdata == CR_BYTE)

  // Error bytes are zero and never close a frame
  `IPF_ASSERT_SAME(a_err_byte, out_tvalid && out_tuser[0], (out_tdata == ERR_BYTE) && !out_tlast)

  // A stalled output byte holds
  `IPF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Nothing is offered right after reset
  `IPF_ASSERT_RST(a_rst_quiet, !rst_n, !out_tvalid)

endmodule

bind inverter_packet_framer ipf_checker u_ipf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Inverter packet framer testbench
// Streams start, payload and stray payload transactions into the framer,
// builds the expected wire bytes of every frame (header, payload, checksum
// and trailer) and checks each output transaction in order, with random
// gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
  import ipf_pkg::*;

  typedef struct {
    logic              mode;
    logic [BYTE_W-1:0] ctrl;
    logic [BYTE_W-1:0] func;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] data;
  } link_item_t;

  typedef struct {
    logic [BYTE_W-1:0] byte_val;
    logic              last;
    logic              err;
  } wire_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [0:0]           in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [BYTE_W-1:0]    out_tdata;
  logic                 out_tlast;
  logic [0:0]           out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  // Items waiting for the driver, wire bytes waiting for the monitor
  link_item_t pending_items[$];
  wire_byte_t wire_bytes_q[$];
  link_item_t cur_item;
  wire_byte_t want_byte;

  // Framer shadow: addresses and the open frame
  logic [BYTE_W-1:0] src_shadow = '0;
  logic [BYTE_W-1:0] dst_shadow = '0;
  logic [SUM_W-1:0]  frame_sum = '0;
  logic [BYTE_W-1:0] frame_left = '0;
  logic              frame_active = 1'b0;

  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned mismatch_count = 0;
  bit          in_idle_on = 1'b1;
  bit          out_stall_on = 1'b1;

  inverter_packet_framer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Hard stop well beyond the slowest legal run
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("[%0t] mismatch on %s: got %02h, expected %02h", $time, what, got, want);
  endtask

  function automatic void push_wire_byte(input logic [BYTE_W-1:0] b, input logic last,
                                         input logic err);
    wire_byte_t w;
    w.byte_val = b;
    w.last = last;
    w.err = err;
    wire_bytes_q.push_back(w);
  endfunction

  // Emit a byte that enters the frame checksum
  function automatic void push_counted(input logic [BYTE_W-1:0] b);
    frame_sum = frame_sum + SUM_W'(b);
    push_wire_byte(b, 1'b0, 1'b0);
  endfunction

  // Append checksum (negated sum, high byte first) and the LF CR trailer
  function automatic void close_frame();
    logic [SUM_W-1:0] ck;
    ck = ~frame_sum + SUM_W'(1);
    push_wire_byte(ck[15:8], 1'b0, 1'b0);
    push_wire_byte(ck[7:0], 1'b0, 1'b0);
    push_wire_byte(LF_BYTE, 1'b0, 1'b0);
    push_wire_byte(CR_BYTE, 1'b1, 1'b0);
    frame_active = 1'b0;
    frame_left = '0;
    frame_sum = '0;
  endfunction

  // Work out the wire bytes that one accepted transaction produces
  function automatic void predict_frame_bytes(input link_item_t it);
    if (it.mode == MODE_START) begin
      frame_sum = '0;
      push_counted(SYNC_BYTE);
      push_counted(SYNC_BYTE);
      push_counted(src_shadow);
      push_counted(dst_shadow);
      push_counted(it.ctrl);
      push_counted(it.func);
      push_counted(it.len);
      frame_left = it.len;
      frame_active = 1'b1;
      if (it.len == '0) close_frame();
    end else if (!frame_active) begin
      push_wire_byte(ERR_BYTE, 1'b0, 1'b1);
    end else begin
      push_counted(it.data);
      frame_left = frame_left - BYTE_W'(1);
      if (frame_left == '0) close_frame();
    end
  endfunction

  // Driver: present queued items, predict on every accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_frame_bytes(cur_item);
        send_gap = in_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (in_tvalid && !in_tready) begin
        // hold the current transaction
      end else if (send_gap != 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        cur_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= cur_item.mode;
        in_tdata <= {cur_item.data, cur_item.len, cur_item.func, cur_item.ctrl};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each output transaction with the oldest expected byte
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (wire_bytes_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 8'h00);
        end else begin
          want_byte = wire_bytes_q.pop_front();
          if (out_tdata !== want_byte.byte_val)
            report_mismatch("out_byte", out_tdata, want_byte.byte_val);
          if (out_tlast !== want_byte.last)
            report_mismatch("frame_end", 8'(out_tlast), 8'(want_byte.last));
          if (out_tuser[0] !== want_byte.err)
            report_mismatch("error", 8'(out_tuser[0]), 8'(want_byte.err));
        end
        recv_stall = out_stall_on ? $urandom_range(0, 3) : 0;
      end
      if (recv_stall != 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Called at a clock edge; leaves cfg_valid high for the caller to drop
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SOURCE_ADDRESS: src_shadow = val;
      REG_DEST_ADDRESS:   dst_shadow = val;
      default: ;
    endcase
  endtask

  task automatic set_addresses(input logic [BYTE_W-1:0] src, input logic [BYTE_W-1:0] dst);
    write_reg(REG_SOURCE_ADDRESS, src);
    write_reg(REG_DEST_ADDRESS, dst);
    cfg_valid <= 1'b0;
  endtask

  function automatic void queue_start(input logic [BYTE_W-1:0] ctrl,
                                      input logic [BYTE_W-1:0] func,
                                      input logic [BYTE_W-1:0] len);
    link_item_t it;
    it.mode = MODE_START;
    it.ctrl = ctrl;
    it.func = func;
    it.len = len;
    it.data = 8'($urandom_range(0, 255));
    pending_items.push_back(it);
  endfunction

  // Unused header fields carry noise on payload transactions
  function automatic void queue_payload(input logic [BYTE_W-1:0] data);
    link_item_t it;
    it.mode = MODE_PAYLOAD;
    it.ctrl = 8'($urandom_range(0, 255));
    it.func = 8'($urandom_range(0, 255));
    it.len = 8'($urandom_range(0, 255));
    it.data = data;
    pending_items.push_back(it);
  endfunction

  // Mostly complete frames; some abandoned frames and stray payload bytes
  task automatic queue_random_traffic(input int unsigned n);
    int unsigned queued;
    int unsigned len;
    int unsigned cut;
    int unsigned pick;
    queued = 0;
    while (queued < n) begin
      case ($urandom_range(0, 9))
        0: begin
          queue_payload(8'($urandom_range(0, 255)));
          queued++;
        end
        1: begin
          len = $urandom_range(1, 255);
          cut = $urandom_range(0, (len > 6) ? 6 : len - 1);
          queue_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len[7:0]);
          repeat (cut) queue_payload(8'($urandom_range(0, 255)));
          queued += cut + 1;
        end
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 2) len = 0;
          else if (pick < 9) len = $urandom_range(1, 8);
          else len = $urandom_range(9, 40);
          queue_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len[7:0]);
          repeat (len) queue_payload(8'($urandom_range(0, 255)));
          queued += len + 1;
        end
      endcase
    end
  endtask

  // Wait until every queued item is accepted and every wire byte has arrived
  task automatic wait_until_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_tvalid || wire_bytes_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: stray bytes after reset, empty frames, field extremes,
    // start while a frame is open
    set_addresses(8'hFF, 8'h00);
    queue_payload(8'hFF);
    queue_payload(8'h00);
    queue_start(8'h00, 8'h00, 8'd0);
    queue_start(8'hFF, 8'hFF, 8'd1);
    queue_payload(8'hFF);
    queue_start(8'h5A, 8'hC3, 8'd3);
    queue_payload(8'h00);
    queue_payload(8'h80);
    queue_payload(8'h7F);
    queue_start(8'h11, 8'h22, 8'd5);
    queue_payload(8'h01);
    queue_payload(8'hFE);
    queue_start(8'h33, 8'h44, 8'd2);
    queue_payload(8'hAA);
    queue_payload(8'h55);
    queue_payload(8'h3C);
    queue_start(8'hFF, 8'h00, 8'd0);
    queue_start(8'h66, 8'h77, 8'd3);
    queue_payload(8'h99);
    wait_until_drained();

    // New addresses while a frame is still open: it keeps the old ones
    set_addresses(8'h00, 8'hFF);
    in_idle_on = 1'b0;
    out_stall_on = 1'b0;
    queue_payload(8'h12);
    queue_payload(8'h34);
    queue_random_traffic(50);
    wait_until_drained();

    set_addresses(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    in_idle_on = 1'b1;
    out_stall_on = 1'b1;
    queue_random_traffic(50);
    wait_until_drained();

    // Longest frame, then more mixed traffic
    set_addresses(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    in_idle_on = 1'b0;
    out_stall_on = 1'b1;
    queue_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd255);
    repeat (255) queue_payload(8'($urandom_range(0, 255)));
    queue_random_traffic(20);
    wait_until_drained();

    set_addresses(8'hFF, 8'hFF);
    in_idle_on = 1'b1;
    out_stall_on = 1'b0;
    queue_random_traffic(50);
    wait_until_drained();

    set_addresses(8'h00, 8'h00);
    in_idle_on = 1'b1;
    out_stall_on = 1'b1;
    queue_random_traffic(50);
    wait_until_drained();

    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
